/* rtl/soft_rectangle_membership_defines.svh */
`ifndef SOFT_RECTANGLE_MEMBERSHIP_DEFINES_SVH
`define SOFT_RECTANGLE_MEMBERSHIP_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define SRM_ASSERT_IMPL(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("srm: same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define SRM_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("srm: next-cycle check failed");

`endif

/* rtl/srm_pkg.sv */
package srm_pkg;

  localparam int RATE_W      = 24;
  localparam int VALUE_W     = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int AXIS_STAGES = 6;
  localparam int PIPE_STAGES = AXIS_STAGES + 2;
  // offset argument spans 0 .. 2^ARG_SHIFT
  localparam int ARG_SHIFT   = 25;
  localparam int U_W         = ARG_SHIFT + 1;

  localparam logic [RATE_W-1:0] RATE_RESET = 24'h100000;

  localparam longint Q30_ONE = longint'(1) <<< 30;
  localparam longint ARG_LIM = longint'(16) <<< 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTRE_X      = 3'd0,
    REG_CENTRE_Y      = 3'd1,
    REG_HALF_LENGTH_X = 3'd2,
    REG_HALF_LENGTH_Y = 3'd3,
    REG_SIGMOID_RATE  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [AXIS_STAGES-1:0] en;
  } axis_ctrl_t;

  // truncating quotient of two non-negative values, shift and subtract, elaboration only
  function automatic longint div_floor(input longint num, input longint den);
    longint quo;
    longint rem;
    quo = 0;
    rem = 0;
    for (int b = 62; b >= 0; b--) begin
      rem = (rem <<< 1) | ((num >>> b) & longint'(1));
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | (longint'(1) <<< b);
      end
    end
    return quo;
  endfunction

  // exp(-f) for f in Q.30, truncated taylor series, elaboration only
  function automatic longint exp_neg_q30(input longint f);
    longint sum;
    longint term;
    sum  = Q30_ONE;
    term = Q30_ONE;
    for (int k = 1; k <= 16; k++) begin
      term = div_floor((term * f) >>> 30, longint'(k));
      if ((k % 2) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return (sum < 0) ? longint'(0) : sum;
  endfunction

  // logistic table entry i of depth entries, Q0.16 saturated
  function automatic longint logistic_entry(input int i, input int depth);
    longint t;
    longint x;
    longint n;
    longint e;
    longint e1;
    longint d;
    longint num;
    longint r;
    t  = -ARG_LIM + div_floor(longint'(i) <<< ARG_SHIFT, longint'(depth));
    x  = (t < 0) ? -t : t;
    n  = x >>> 20;
    e  = exp_neg_q30((x & longint'(20'hFFFFF)) <<< 10);
    e1 = exp_neg_q30(Q30_ONE);
    for (longint j = 0; j < n; j++) begin
      e = (e * e1) >>> 30;
    end
    d   = Q30_ONE + e;
    num = (t >= 0) ? (longint'(1) <<< 46) : (e <<< 16);
    r   = div_floor(num + (d >>> 1), d);
    return (r > 65535) ? longint'(65535) : r;
  endfunction

endpackage

/* rtl/srm_axis.sv */
module srm_axis #(
  parameter int COORD_WIDTH = 16,
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                             clk_i,
  input  srm_pkg::axis_ctrl_t              ctrl_i,
  input  logic signed [COORD_WIDTH-1:0]    point_i,
  input  logic signed [COORD_WIDTH-1:0]    centre_i,
  input  logic [COORD_WIDTH-2:0]           half_length_i,
  input  logic [srm_pkg::RATE_W-1:0]       rate_i,
  output logic [srm_pkg::VALUE_W-1:0]      value_o
);
  import srm_pkg::*;

  localparam int MW = COORD_WIDTH + 2;
  localparam int AW = MW + RATE_W + 1;
  localparam int DW = $clog2(TABLE_DEPTH + 1);
  localparam int PW = U_W + DW;
  localparam int IW = $clog2(TABLE_DEPTH);
  localparam logic signed [AW-1:0] LIM_P = AW'(ARG_LIM);
  localparam logic signed [AW-1:0] LIM_N = -LIM_P;
  localparam logic [U_W-1:0] U_MAX = U_W'(2 * ARG_LIM);
  localparam logic [U_W-1:0] U_MID = U_W'(ARG_LIM);

  logic signed [MW-1:0] m1_q, m2_q, m_q;
  logic signed [AW-1:0] a_q, a_d;
  logic [U_W-1:0]       u_q, u_d;
  logic [IW-1:0]        idx_q, idx_d;
  logic [VALUE_W-1:0]   value_q;

  logic signed [MW-1:0] p_ext, c_ext, h_ext;
  logic signed [AW-1:0] m_ext, rate_ext;
  logic [PW-1:0]        scaled;
  logic [PW-ARG_SHIFT-1:0] coarse;

  logic [VALUE_W-1:0] rom_w [TABLE_DEPTH];

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_rom
    localparam logic [VALUE_W-1:0] ENTRY = VALUE_W'(logistic_entry(g, TABLE_DEPTH));
    assign rom_w[g] = ENTRY;
  end

  assign p_ext    = MW'(point_i);
  assign c_ext    = MW'(centre_i);
  assign h_ext    = $signed(MW'(half_length_i));
  assign m_ext    = AW'(m_q);
  assign rate_ext = $signed(AW'(rate_i));

  always_comb begin
    a_d = m_ext * rate_ext;
  end

  // clamp to +-16 and shift to an unsigned offset
  always_comb begin
    priority if (a_q > LIM_P) begin
      u_d = U_MAX;
    end else if (a_q < LIM_N) begin
      u_d = '0;
    end else begin
      u_d = a_q[U_W-1:0] + U_MID;
    end
  end

  always_comb begin
    scaled = PW'(u_q) * PW'(TABLE_DEPTH);
    coarse = scaled[PW-1:ARG_SHIFT];
    if (coarse > (PW-ARG_SHIFT)'(TABLE_DEPTH - 1)) begin
      idx_d = IW'(TABLE_DEPTH - 1);
    end else begin
      idx_d = coarse[IW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[0]) begin
      m1_q <= c_ext + h_ext - p_ext;
      m2_q <= p_ext - c_ext + h_ext;
    end
    if (ctrl_i.en[1]) begin
      m_q <= (m1_q < m2_q) ? m1_q : m2_q;
    end
    if (ctrl_i.en[2]) begin
      a_q <= a_d;
    end
    if (ctrl_i.en[3]) begin
      u_q <= u_d;
    end
    if (ctrl_i.en[4]) begin
      idx_q <= idx_d;
    end
    if (ctrl_i.en[5]) begin
      value_q <= rom_w[idx_q];
    end
  end

  assign value_o = value_q;

endmodule

/* rtl/soft_rectangle_membership.sv */
// throughput: one point per cycle while membership_stall_i is low; eight
// register stages, the rate multiplier and the logistic rom read each own
// a stage, every stage stalls independently
// reset (rst_ni low, asynchronous): pipeline valid bits clear, rectangle
// registers clear to zero and the rate returns to 1.0
module soft_rectangle_membership #(
  parameter int TABLE_DEPTH = 1024,
  parameter int COORD_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [srm_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [((COORD_WIDTH > srm_pkg::RATE_W) ? COORD_WIDTH : srm_pkg::RATE_W)-1:0]
                                              cfg_data_i,
  input  logic                                point_valid_i,
  output logic                                point_stall_o,
  input  logic signed [COORD_WIDTH-1:0]       point_x_i,
  input  logic signed [COORD_WIDTH-1:0]       point_y_i,
  output logic                                membership_valid_o,
  input  logic                                membership_stall_i,
  output logic [srm_pkg::VALUE_W-1:0]         membership_o
);
  import srm_pkg::*;

  `include "soft_rectangle_membership_defines.svh"

  localparam int LAST = PIPE_STAGES - 1;

  logic signed [COORD_WIDTH-1:0] centre_x_q, centre_y_q;
  logic [COORD_WIDTH-2:0]        half_x_q, half_y_q;
  logic [RATE_W-1:0]             rate_q;

  logic [PIPE_STAGES-1:0] valid_q, valid_d, ready;
  axis_ctrl_t             axis_ctrl;
  logic [VALUE_W-1:0]     sx, sy;
  logic [2*VALUE_W-1:0]   prod_q;
  logic [2*VALUE_W:0]     rounded;
  logic [VALUE_W-1:0]     out_q, out_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      centre_x_q <= '0;
      centre_y_q <= '0;
      half_x_q   <= '0;
      half_y_q   <= '0;
      rate_q     <= RATE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_CENTRE_X:      centre_x_q <= cfg_data_i[COORD_WIDTH-1:0];
        REG_CENTRE_Y:      centre_y_q <= cfg_data_i[COORD_WIDTH-1:0];
        REG_HALF_LENGTH_X: half_x_q   <= cfg_data_i[COORD_WIDTH-2:0];
        REG_HALF_LENGTH_Y: half_y_q   <= cfg_data_i[COORD_WIDTH-2:0];
        REG_SIGMOID_RATE:  rate_q     <= cfg_data_i[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // a stage loads when it is empty or the stage after it moves on
  always_comb begin
    ready[LAST] = !valid_q[LAST] || !membership_stall_i;
    for (int k = LAST - 1; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
    valid_d[0] = ready[0] ? point_valid_i : valid_q[0];
    for (int k = 1; k < PIPE_STAGES; k++) begin
      valid_d[k] = ready[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign axis_ctrl.en = ready[AXIS_STAGES-1:0];

  srm_axis #(
    .COORD_WIDTH (COORD_WIDTH),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_axis_x (
    .clk_i         (clk_i),
    .ctrl_i        (axis_ctrl),
    .point_i       (point_x_i),
    .centre_i      (centre_x_q),
    .half_length_i (half_x_q),
    .rate_i        (rate_q),
    .value_o       (sx)
  );

  srm_axis #(
    .COORD_WIDTH (COORD_WIDTH),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_axis_y (
    .clk_i         (clk_i),
    .ctrl_i        (axis_ctrl),
    .point_i       (point_y_i),
    .centre_i      (centre_y_q),
    .half_length_i (half_y_q),
    .rate_i        (rate_q),
    .value_o       (sy)
  );

  // round half up to Q0.16, saturate
  always_comb begin
    rounded = (2*VALUE_W+1)'(prod_q) + (2*VALUE_W+1)'(1 << (VALUE_W - 1));
    if (rounded[2*VALUE_W]) begin
      out_d = '1;
    end else begin
      out_d = rounded[2*VALUE_W-1:VALUE_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready[AXIS_STAGES]) begin
      prod_q <= sx * sy;
    end
    if (ready[LAST]) begin
      out_q <= out_d;
    end
  end

  assign point_stall_o      = !ready[0];
  assign membership_valid_o = valid_q[LAST];
  assign membership_o       = out_q;

  `SRM_ASSERT_IMPL(a_free_flow, clk_i, rst_ni, !membership_stall_i, !point_stall_o)
  `SRM_ASSERT_IMPL(a_empty_head_accepts, clk_i, rst_ni, !valid_q[0], !point_stall_o)
  `SRM_ASSERT_NEXT(a_accept_enters, clk_i, rst_ni, point_valid_i && !point_stall_o, valid_q[0])

endmodule

/* bench/soft_rectangle_membership_tb.sv */
`timescale 1ns / 100ps

module soft_rectangle_membership_tb;
  import srm_pkg::*;

  localparam int ROM_DEPTH = 1024;
  localparam int COORD_W = 16;
  localparam int PHASE_ITEMS = 250;
  localparam int RANDOM_PHASES = 8;
  localparam int TAIL_CYCLES = PIPE_STAGES + 4;
  localparam int QUIET_LIMIT = 2000;
  localparam longint LOGIT_LIMIT = longint'(16) <<< 20;
  localparam longint Q30 = longint'(1) <<< 30;

  // expected membership words and the rectangle they were computed against
  class membership_board;
    logic [VALUE_W-1:0] logistic_rom [ROM_DEPTH];
    logic signed [COORD_W-1:0] centre_x;
    logic signed [COORD_W-1:0] centre_y;
    logic [COORD_W-2:0] half_x;
    logic [COORD_W-2:0] half_y;
    logic [RATE_W-1:0] rate;
    logic [VALUE_W-1:0] pending_membership [$];
    longint inv_e;
    int failures;

    function new();
      inv_e = taylor_exp_neg(Q30);
      for (int i = 0; i < ROM_DEPTH; i++) begin
        logistic_rom[i] = VALUE_W'(logistic_at(i));
      end
      centre_x = '0;
      centre_y = '0;
      half_x = '0;
      half_y = '0;
      rate = RATE_RESET;
      failures = 0;
    endfunction

    // exp(-f), f and result in Q.30, 16 truncated terms
    function longint taylor_exp_neg(longint f);
      longint acc;
      longint term;
      acc = Q30;
      term = Q30;
      for (int k = 1; k <= 16; k++) begin
        term = ((term * f) >>> 30) / longint'(k);
        acc = (k % 2 == 1) ? acc - term : acc + term;
      end
      return (acc < 0) ? longint'(0) : acc;
    endfunction

    function longint logistic_at(int slot);
      longint t;
      longint mag;
      longint e;
      longint denom;
      longint num;
      longint q;
      t = -LOGIT_LIMIT + ((longint'(slot) <<< 25) / longint'(ROM_DEPTH));
      mag = (t < 0) ? -t : t;
      e = taylor_exp_neg((mag % (longint'(1) <<< 20)) <<< 10);
      // whole part of the argument, one factor of 1/e at a time
      for (longint k = 0; k < (mag >>> 20); k++) begin
        e = (e * inv_e) >>> 30;
      end
      denom = Q30 + e;
      num = (t >= 0) ? (longint'(1) <<< 46) : (e <<< 16);
      q = (num + denom / 2) / denom;
      return (q > 65535) ? longint'(65535) : q;
    endfunction

    function logic [VALUE_W-1:0] axis_weight(longint p, longint c, longint h);
      longint to_hi;
      longint to_lo;
      longint margin;
      longint arg;
      longint slot;
      to_hi = (c + h) - p;
      to_lo = p - (c - h);
      margin = (to_hi < to_lo) ? to_hi : to_lo;
      arg = margin * longint'(rate);
      if (arg > LOGIT_LIMIT) arg = LOGIT_LIMIT;
      if (arg < -LOGIT_LIMIT) arg = -LOGIT_LIMIT;
      slot = ((arg + LOGIT_LIMIT) * longint'(ROM_DEPTH)) >>> 25;
      if (slot > ROM_DEPTH - 1) slot = ROM_DEPTH - 1;
      return logistic_rom[slot];
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [RATE_W-1:0] data);
      case (idx)
        REG_CENTRE_X: centre_x = data[COORD_W-1:0];
        REG_CENTRE_Y: centre_y = data[COORD_W-1:0];
        REG_HALF_LENGTH_X: half_x = data[COORD_W-2:0];
        REG_HALF_LENGTH_Y: half_y = data[COORD_W-2:0];
        REG_SIGMOID_RATE: rate = data;
        default: ;
      endcase
    endfunction

    function void note_point(logic signed [COORD_W-1:0] px, logic signed [COORD_W-1:0] py);
      longint wx;
      longint wy;
      longint prod;
      wx = axis_weight(px, centre_x, half_x);
      wy = axis_weight(py, centre_y, half_y);
      prod = (wx * wy + 32768) >>> 16;
      if (prod > 65535) prod = 65535;
      pending_membership.push_back(VALUE_W'(prod));
    endfunction

    function void check_membership(logic [VALUE_W-1:0] got);
      logic [VALUE_W-1:0] want;
      if (pending_membership.size() == 0) begin
        $error("membership: no word expected, got %0d", got);
        failures++;
      end else begin
        want = pending_membership.pop_front();
        if (want !== got) begin
          $error("membership: expected %0d, got %0d", want, got);
          failures++;
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [RATE_W-1:0] cfg_data_i;
  logic point_valid_i;
  logic point_stall_o;
  logic signed [COORD_W-1:0] point_x_i;
  logic signed [COORD_W-1:0] point_y_i;
  logic membership_valid_o;
  logic membership_stall_i;
  logic [VALUE_W-1:0] membership_o;

  membership_board board;
  bit idling_on;
  int shape_cx;
  int shape_cy;
  int shape_hx;
  int shape_hy;
  int quiet_cycles;

  soft_rectangle_membership #(
    .TABLE_DEPTH(ROM_DEPTH),
    .COORD_WIDTH(COORD_W)
  ) i_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .point_valid_i(point_valid_i),
    .point_stall_o(point_stall_o),
    .point_x_i(point_x_i),
    .point_y_i(point_y_i),
    .membership_valid_o(membership_valid_o),
    .membership_stall_i(membership_stall_i),
    .membership_o(membership_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!idling_on || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // bias toward the rectangle edges where the logistic actually moves
  function automatic logic [COORD_W-1:0] pick_coord(int c, int h);
    int unsigned roll;
    int span;
    int spot;
    roll = $urandom_range(0, 99);
    span = (roll % 3 == 0) ? 8 : ((roll % 3 == 1) ? 160 : 3000);
    if (roll < 25) return COORD_W'($urandom);
    if (roll < 40) return COORD_W'(c - h + int'($urandom_range(0, 2 * h)));
    spot = roll[0] ? c + h : c - h;
    return COORD_W'(spot + int'($urandom_range(0, 2 * span)) - span);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) board.set_register(cfg_index_i, cfg_data_i);
      if (point_valid_i && !point_stall_o) board.note_point(point_x_i, point_y_i);
      if (membership_valid_o && !membership_stall_i) board.check_membership(membership_o);
      if (cfg_we_i || (point_valid_i && !point_stall_o) ||
          (membership_valid_o && !membership_stall_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // receiver back-pressure
  initial begin : output_stall
    int run_len;
    int hold_len;
    membership_stall_i <= 1'b0;
    forever begin
      run_len = $urandom_range(1, 12);
      hold_len = pick_gap();
      membership_stall_i <= 1'b0;
      repeat (run_len) @(posedge clk_i);
      if (hold_len > 0) begin
        membership_stall_i <= 1'b1;
        repeat (hold_len) @(posedge clk_i);
      end
    end
  end

  task automatic send_point(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      point_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    point_valid_i <= 1'b1;
    point_x_i <= px;
    point_y_i <= py;
    do @(posedge clk_i); while (point_stall_o);
  endtask

  task automatic wait_drained();
    point_valid_i <= 1'b0;
    // the last word accepted is noted by the monitor at that same edge
    @(posedge clk_i);
    while (board.pending_membership.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  // junk above each register's width must be dropped by the block
  task automatic apply_config(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
                              input logic [COORD_W-2:0] hx, input logic [COORD_W-2:0] hy,
                              input logic [RATE_W-1:0] rate);
    wait_drained();
    put_reg(REG_CENTRE_X, {8'($urandom), cx});
    put_reg(REG_CENTRE_Y, {8'($urandom), cy});
    put_reg(REG_HALF_LENGTH_X, {9'($urandom), hx});
    put_reg(REG_HALF_LENGTH_Y, {9'($urandom), hy});
    put_reg(REG_SIGMOID_RATE, rate);
    // unmapped indexes must not disturb anything
    for (int k = int'(REG_SIGMOID_RATE) + 1; k < (1 << CFG_IDX_W); k++) begin
      put_reg(CFG_IDX_W'(k), RATE_W'($urandom));
    end
    cfg_we_i <= 1'b0;
    shape_cx = int'($signed(cx));
    shape_cy = int'($signed(cy));
    shape_hx = int'(hx);
    shape_hy = int'(hy);
  endtask

  initial begin
    board = new();
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i <= '0;
    point_valid_i <= 1'b0;
    point_x_i <= '0;
    point_y_i <= '0;
    quiet_cycles = 0;
    idling_on = 1'b1;
    shape_cx = 0;
    shape_cy = 0;
    shape_hx = 0;
    shape_hy = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset rectangle is a single point, every point lies outside it or on its edge
    send_point(16'h0000, 16'h0000);
    send_point(16'h7FFF, 16'h8000);
    send_point(16'h8000, 16'h7FFF);
    send_point(16'hFFFF, 16'h0001);
    send_point(16'h0010, 16'hFFF0);
    send_point(16'hFFEF, 16'h0011);
    send_point(16'h0005, 16'h0000);
    send_point(16'h7FFF, 16'h7FFF);

    apply_config(16'd0, 16'd0, 15'd1000, 15'd1000, RATE_RESET);
    send_point(16'd0, 16'd0);
    send_point(16'd1000, -16'sd1000);
    send_point(16'd1016, 16'd0);
    send_point(16'd984, -16'sd984);
    send_point(16'd1017, 16'd1017);
    send_point(-16'sd1100, 16'd500);
    send_point(16'h8000, 16'h7FFF);
    send_point(16'd999, 16'd1001);

    // zero rate pins both axes to one half
    apply_config(16'h7FFF, 16'h8000, 15'h7FFF, 15'h7FFF, 24'd0);
    send_point(16'h0000, 16'h0000);
    send_point(16'h8000, 16'h8000);
    send_point(16'h7FFF, 16'h7FFF);

    apply_config(16'h8000, 16'h7FFF, 15'd0, 15'd0, 24'hFFFFFF);
    send_point(16'h8000, 16'h7FFF);
    send_point(16'h8001, 16'h7FFE);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: apply_config(16'd0, 16'd0, 15'd200, 15'd50, RATE_RESET);
        1: apply_config(16'($urandom), 16'($urandom), 15'($urandom_range(0, 3000)),
                        15'($urandom_range(0, 3000)), 24'($urandom_range(1 << 14, 1 << 22)));
        2: apply_config(16'h8000, 16'h7FFF, 15'h7FFF, 15'd0, 24'hFFFFFF);
        3: apply_config(16'h7FFF, 16'h8000, 15'd0, 15'h7FFF, 24'd0);
        4: apply_config(16'($urandom), 16'($urandom), 15'h7FFF, 15'h7FFF, 24'd1);
        5: apply_config(16'd100, -16'sd100, 15'd5, 15'd5, 24'($urandom));
        6: apply_config(16'($urandom), 16'($urandom), 15'($urandom), 15'($urandom),
                        24'($urandom));
        default: apply_config(16'd0, 16'd0, 15'h7FFF, 15'h7FFF, 24'h010000);
      endcase
      idling_on = (phase != 3) && (phase != 5);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // let the pipe run dry once per phase
        if (n == PHASE_ITEMS / 2) wait_drained();
        send_point(pick_coord(shape_cx, shape_hx), pick_coord(shape_cy, shape_hy));
      end
    end

    wait_drained();
    if (board.failures == 0 && board.pending_membership.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
